// ===== src/m68kfse_pkg.sv =====
// shared types and constants for the 68000 subset step executor
package m68kfse_pkg;

    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 120;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_REFUSE = 3'd0;
    localparam kind_t KIND_BCC    = 3'd1;
    localparam kind_t KIND_DBCC   = 3'd2;
    localparam kind_t KIND_ADDQ_D = 3'd3;
    localparam kind_t KIND_ADDQ_A = 3'd4;
    localparam kind_t KIND_LEA    = 3'd5;
    localparam kind_t KIND_ADD_L  = 3'd6;

    // classified instruction as it travels from front to back
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  cc;
        logic [1:0]  sz;
        logic [3:0]  imm;
        logic [2:0]  rs;
        logic [2:0]  rd;
        logic        short_br;
        logic        use_an;
        logic        mem_src;
        logic        postinc;
        logic        fault;
        logic [7:0]  base;
        logic [31:0] pc;
        logic [31:0] seq_pc;
        logic [31:0] target;
        logic [31:0] rdata;
    } item_t;

endpackage

// ===== src/m68kfse_front.sv =====
// front end: accepts instructions and classifies them
module m68kfse_front
    import m68kfse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    output logic                push_valid,
    input  logic                push_ready,
    output item_t               push_item,
    output logic                busy
);

    logic [15:0] op;
    logic [15:0] e1;
    logic [15:0] e2;
    logic [31:0] pc;
    logic [7:0]  base;
    logic [31:0] x8;
    logic [31:0] x16;
    logic [2:0]  mode;
    logic [2:0]  rg;
    logic [2:0]  r9;
    logic [1:0]  sz;
    logic [31:0] pc2;
    logic        seen_reg;
    logic        seen_next;

    assign op   = s_tdata[15:0];
    assign e1   = s_tdata[31:16];
    assign e2   = s_tdata[47:32];
    assign pc   = s_tdata[79:48];
    assign base = s_tdata[87:80];
    assign x8   = {{24{op[7]}}, op[7:0]};
    assign x16  = {{16{e1[15]}}, e1};
    assign mode = op[5:3];
    assign rg   = op[2:0];
    assign r9   = op[11:9];
    assign sz   = op[7:6];
    assign pc2  = pc + 32'd2;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    // activity marker for the top level, set for one cycle after a transfer in
    assign seen_next = s_tvalid && push_ready;
    assign busy      = seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    always_comb
    begin
        push_item          = '0;
        push_item.cc       = op[11:8];
        push_item.sz       = sz;
        push_item.imm      = (r9 == 3'd0) ? 4'd8 : {1'b0, r9};
        push_item.rs       = rg;
        push_item.rd       = r9;
        push_item.fault    = s_tuser;
        push_item.base     = (base == 8'd0) ? 8'd1 : base;
        push_item.pc       = pc;
        push_item.rdata    = s_tdata[119:88];
        push_item.seq_pc   = pc2;
        push_item.target   = pc2 + x16;
        push_item.kind     = KIND_REFUSE;
        priority if (op[15:12] == 4'h6)
        begin
            push_item.short_br = (op[7:0] != 8'd0);
            push_item.kind     = (op[11:8] == 4'h1) ? KIND_REFUSE : KIND_BCC;
            if (op[7:0] != 8'd0)
            begin
                push_item.target = pc2 + x8;
            end
            else
            begin
                push_item.seq_pc = pc + 32'd4;
            end
        end
        else if ((op & 16'hF0F8) == 16'h50C8)
        begin
            push_item.kind   = KIND_DBCC;
            push_item.seq_pc = pc + 32'd4;
        end
        else if ((op & 16'hF100) == 16'h5000)
        begin
            if (mode == 3'd0 && sz != 2'd3)
            begin
                push_item.kind = KIND_ADDQ_D;
            end
            else if (mode == 3'd1 && (sz == 2'd1 || sz == 2'd2))
            begin
                push_item.kind = KIND_ADDQ_A;
            end
        end
        else if ((op & 16'hF1C0) == 16'h41C0)
        begin
            push_item.kind   = KIND_LEA;
            push_item.seq_pc = pc + 32'd4;
            // target holds the ea offset added to An (or the whole ea)
            priority if (mode == 3'd7 && rg == 3'd0)
            begin
                push_item.target = x16;
            end
            else if (mode == 3'd7 && rg == 3'd1)
            begin
                push_item.target = {e1, e2};
                push_item.seq_pc = pc + 32'd6;
            end
            else if (mode == 3'd2)
            begin
                push_item.use_an = 1'b1;
                push_item.target = '0;
                push_item.seq_pc = pc2;
            end
            else if (mode == 3'd5)
            begin
                push_item.use_an = 1'b1;
                push_item.target = x16;
            end
            else if (mode == 3'd7 && rg == 3'd2)
            begin
                push_item.target = pc2 + x16;
            end
            else
            begin
                push_item.kind = KIND_REFUSE;
            end
        end
        else if ((op & 16'hF1C0) == 16'hD080)
        begin
            if (mode == 3'd0)
            begin
                push_item.kind = KIND_ADD_L;
            end
            else if (mode == 3'd2 || mode == 3'd3)
            begin
                push_item.kind    = KIND_ADD_L;
                push_item.mem_src = 1'b1;
                push_item.postinc = (mode == 3'd3);
            end
        end
        else
        begin
            push_item.kind = KIND_REFUSE;
        end
    end

endmodule

// ===== src/m68kfse_queue.sv =====
// short queue of classified instructions between front and back
module m68kfse_queue
    import m68kfse_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_pop,
    output item_t out_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== src/m68kfse_back.sv =====
// back end: register read, execute, register file and flag update, result register
module m68kfse_back
    import m68kfse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  item_t               q_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser
);

    localparam logic [1:0] CFG_BCC_BYTE = 2'd0;
    localparam logic [1:0] CFG_BCC_WORD = 2'd1;
    localparam logic [1:0] CFG_DB_LOOP  = 2'd2;
    localparam logic [1:0] CFG_DB_EXP   = 2'd3;

    // configuration
    logic [5:0]  adj_byte_reg;
    logic [5:0]  adj_word_reg;
    logic [5:0]  adj_loop_reg;
    logic [5:0]  adj_exp_reg;

    // register file: data and address banks, with written marks
    logic [31:0] d_mem [8];
    logic [31:0] a_mem [8];
    logic [7:0]  d_vld_reg;
    logic [7:0]  a_vld_reg;
    logic [7:0]  d_vld_next;
    logic [7:0]  a_vld_next;
    logic        d_we;
    logic [2:0]  d_wa;
    logic [31:0] d_wd;
    logic        a_we;
    logic [2:0]  a_wa;
    logic [31:0] a_wd;

    // execute stage
    logic        s1_valid_reg;
    item_t       s1_item_reg;
    logic [31:0] d_rs_raw_reg;
    logic [31:0] d_rd_raw_reg;
    logic [31:0] a_rs_raw_reg;
    logic [31:0] d_byp_reg;
    logic [31:0] a_byp_reg;
    logic        d_rs_hit_reg;
    logic        d_rd_hit_reg;
    logic        a_rs_hit_reg;
    logic        d_rs_vld_reg;
    logic        d_rd_vld_reg;
    logic        a_rs_vld_reg;
    logic [31:0] d_rs;
    logic [31:0] d_rd;
    logic [31:0] a_rs;
    logic [4:0]  flags_reg;
    logic        commit;

    // result of the execute stage
    logic        r_handled;
    logic [31:0] r_npc;
    logic [8:0]  r_cyc;
    logic [31:0] r_raddr;
    logic        r_dv;
    logic [3:0]  r_dreg;
    logic [31:0] r_dval;
    logic        r_pv;
    logic [2:0]  r_preg;
    logic        r_fwe;
    logic [4:0]  r_flags;
    logic [4:0]  flags_next;

    // output register
    logic        m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic        m_tuser_reg;

    // arithmetic
    logic        cond;
    logic [15:0] ctr;
    logic [8:0]  sum8;
    logic [16:0] sum16;
    logic [32:0] sum32;
    logic [31:0] src32;
    logic [31:0] dst32;
    logic [4:0]  f8;
    logic [4:0]  f16;
    logic [4:0]  f32;
    logic [31:0] lea_ea;

    function automatic logic cond_true(input logic [3:0] cc, input logic [4:0] f);
        logic c;
        logic v;
        logic z;
        logic n;
        logic t;
        c = f[0];
        v = f[1];
        z = f[2];
        n = f[3];
        unique case (cc)
            4'h0:    t = 1'b1;
            4'h1:    t = 1'b0;
            4'h2:    t = !c && !z;
            4'h3:    t = c || z;
            4'h4:    t = !c;
            4'h5:    t = c;
            4'h6:    t = !z;
            4'h7:    t = z;
            4'h8:    t = !v;
            4'h9:    t = v;
            4'hA:    t = !n;
            4'hB:    t = n;
            4'hC:    t = (n == v);
            4'hD:    t = (n != v);
            4'hE:    t = !z && (n == v);
            default: t = z || (n != v);
        endcase
        return t;
    endfunction

    // base plus signed adjustment, floored at one
    function automatic logic [8:0] cyc_calc(input logic [7:0] base, input logic [5:0] adj);
        logic [9:0] s;
        s = {2'b00, base} + {{4{adj[5]}}, adj};
        return (s[9] || s == 10'd0) ? 9'd1 : s[8:0];
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_byte_reg <= 6'h3E;
            adj_word_reg <= 6'h02;
            adj_loop_reg <= 6'h3E;
            adj_exp_reg  <= 6'h02;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BCC_BYTE: adj_byte_reg <= cfg_data;
                CFG_BCC_WORD: adj_word_reg <= cfg_data;
                CFG_DB_LOOP:  adj_loop_reg <= cfg_data;
                CFG_DB_EXP:   adj_exp_reg  <= cfg_data;
                default:      adj_exp_reg  <= adj_exp_reg;
            endcase
        end
    end

    assign commit = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign q_pop  = q_valid && (!s1_valid_reg || commit);

    // operand select: same-edge write wins, unwritten entries read as zero
    assign d_rs = d_rs_hit_reg ? d_byp_reg : (d_rs_vld_reg ? d_rs_raw_reg : '0);
    assign d_rd = d_rd_hit_reg ? d_byp_reg : (d_rd_vld_reg ? d_rd_raw_reg : '0);
    assign a_rs = a_rs_hit_reg ? a_byp_reg : (a_rs_vld_reg ? a_rs_raw_reg : '0);

    assign cond   = cond_true(s1_item_reg.cc, flags_reg);
    assign ctr    = d_rs[15:0] - 16'd1;
    assign sum8   = {1'b0, d_rs[7:0]} + {5'b0, s1_item_reg.imm};
    assign sum16  = {1'b0, d_rs[15:0]} + {13'b0, s1_item_reg.imm};
    assign src32  = (s1_item_reg.kind == KIND_ADD_L) ?
                    (s1_item_reg.mem_src ? s1_item_reg.rdata : d_rs) :
                    {28'b0, s1_item_reg.imm};
    assign dst32  = (s1_item_reg.kind == KIND_ADD_L) ? d_rd : d_rs;
    assign sum32  = {1'b0, src32} + {1'b0, dst32};
    assign lea_ea = (s1_item_reg.use_an ? a_rs : 32'd0) + s1_item_reg.target;

    // flags X N Z V C
    assign f8  = {sum8[8], sum8[7], (sum8[7:0] == 8'd0),
                  ((~d_rs[7]) & (d_rs[7] ^ sum8[7]) & sum8[7]) |
                  ((d_rs[7] ^ sum8[7]) & (1'b0 ^ sum8[7]) & 1'b0), sum8[8]};
    assign f16 = {sum16[16], sum16[15], (sum16[15:0] == 16'd0),
                  (~d_rs[15]) & sum16[15], sum16[16]};
    assign f32 = {sum32[32], sum32[31], (sum32[31:0] == 32'd0),
                  (src32[31] ^ sum32[31]) & (dst32[31] ^ sum32[31]), sum32[32]};

    always_comb
    begin
        r_handled = 1'b1;
        r_npc     = s1_item_reg.seq_pc;
        r_cyc     = cyc_calc(s1_item_reg.base, 6'd0);
        r_raddr   = '0;
        r_dv      = 1'b0;
        r_dreg    = '0;
        r_dval    = '0;
        r_pv      = 1'b0;
        r_preg    = '0;
        r_fwe     = 1'b0;
        r_flags   = flags_reg;
        unique case (s1_item_reg.kind)
            KIND_BCC:
            begin
                if (cond)
                begin
                    r_npc = s1_item_reg.target;
                end
                else
                begin
                    r_cyc = cyc_calc(s1_item_reg.base,
                                     s1_item_reg.short_br ? adj_byte_reg : adj_word_reg);
                end
            end
            KIND_DBCC:
            begin
                if (!cond)
                begin
                    r_dv   = 1'b1;
                    r_dreg = {1'b0, s1_item_reg.rs};
                    r_dval = {d_rs[31:16], ctr};
                    if (ctr != 16'hFFFF)
                    begin
                        r_npc = s1_item_reg.target;
                        r_cyc = cyc_calc(s1_item_reg.base, adj_loop_reg);
                    end
                    else
                    begin
                        r_cyc = cyc_calc(s1_item_reg.base, adj_exp_reg);
                    end
                end
            end
            KIND_ADDQ_D:
            begin
                r_dv   = 1'b1;
                r_dreg = {1'b0, s1_item_reg.rs};
                r_fwe  = 1'b1;
                unique case (s1_item_reg.sz)
                    2'd0:
                    begin
                        r_dval  = {d_rs[31:8], sum8[7:0]};
                        r_flags = f8;
                    end
                    2'd1:
                    begin
                        r_dval  = {d_rs[31:16], sum16[15:0]};
                        r_flags = f16;
                    end
                    default:
                    begin
                        r_dval  = sum32[31:0];
                        r_flags = f32;
                    end
                endcase
            end
            KIND_ADDQ_A:
            begin
                r_dv   = 1'b1;
                r_dreg = {1'b1, s1_item_reg.rs};
                r_dval = a_rs + {28'b0, s1_item_reg.imm};
            end
            KIND_LEA:
            begin
                r_dv   = 1'b1;
                r_dreg = {1'b1, s1_item_reg.rd};
                r_dval = lea_ea;
            end
            KIND_ADD_L:
            begin
                if (s1_item_reg.mem_src)
                begin
                    r_raddr = a_rs;
                end
                if (s1_item_reg.mem_src && s1_item_reg.fault)
                begin
                    r_handled = 1'b0;
                    r_npc     = s1_item_reg.pc;
                    r_cyc     = '0;
                end
                else
                begin
                    r_dv    = 1'b1;
                    r_dreg  = {1'b0, s1_item_reg.rd};
                    r_dval  = sum32[31:0];
                    r_fwe   = 1'b1;
                    r_flags = f32;
                    r_pv    = s1_item_reg.postinc;
                    r_preg  = s1_item_reg.postinc ? s1_item_reg.rs : 3'd0;
                end
            end
            default:
            begin
                r_handled = 1'b0;
                r_npc     = s1_item_reg.pc;
                r_cyc     = '0;
            end
        endcase
    end

    // register file writes at commit
    assign d_we = commit && r_dv && !r_dreg[3];
    assign d_wa = r_dreg[2:0];
    assign d_wd = r_dval;
    assign a_we = commit && ((r_dv && r_dreg[3]) || r_pv);
    assign a_wa = r_pv ? r_preg : r_dreg[2:0];
    assign a_wd = r_pv ? (a_rs + 32'd4) : r_dval;

    always_comb
    begin
        d_vld_next = d_vld_reg;
        a_vld_next = a_vld_reg;
        if (d_we)
        begin
            d_vld_next[d_wa] = 1'b1;
        end
        if (a_we)
        begin
            a_vld_next[a_wa] = 1'b1;
        end
    end

    assign flags_next = (commit && r_fwe) ? r_flags : flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg    <= '0;
            a_vld_reg    <= '0;
            flags_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= d_vld_next;
            a_vld_reg <= a_vld_next;
            flags_reg <= flags_next;
            if (q_pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            d_mem[d_wa] <= d_wd;
        end
        if (a_we)
        begin
            a_mem[a_wa] <= a_wd;
        end
        if (q_pop)
        begin
            s1_item_reg  <= q_item;
            d_rs_raw_reg <= d_mem[q_item.rs];
            d_rd_raw_reg <= d_mem[q_item.rd];
            a_rs_raw_reg <= a_mem[q_item.rs];
            d_byp_reg    <= d_wd;
            a_byp_reg    <= a_wd;
            d_rs_hit_reg <= d_we && (d_wa == q_item.rs);
            d_rd_hit_reg <= d_we && (d_wa == q_item.rd);
            a_rs_hit_reg <= a_we && (a_wa == q_item.rs);
            d_rs_vld_reg <= d_vld_reg[q_item.rs];
            d_rd_vld_reg <= d_vld_reg[q_item.rd];
            a_rs_vld_reg <= a_vld_reg[q_item.rs];
        end
        if (commit)
        begin
            m_tuser_reg <= r_handled;
            m_tdata_reg <= {1'b0, flags_next, r_preg, r_pv, r_dval, r_dreg, r_dv,
                            r_raddr, r_cyc, r_npc};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== src/m68k_fast_step_executor_core.sv =====
// top level of the 68000 subset step executor
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  s_       | s_tvalid / s_tready   | s_tdata (instruction item), s_tuser (fault)
//  m_       | m_tvalid / m_tready   | m_tdata (step result), m_tuser (handled)
//  cfg_     | cfg_valid / cfg_ready | cfg_index, cfg_data (cycle adjustments)
//
// one instruction per cycle sustained while the output is not stalled; a result passes the queue
// slot, the execute stage register (register read) and the output register (execute/commit)
// register writes are bypassed into the following instruction's operand read
// reset clears the register file marks, flags, queue and valids; config regs
// take their default adjustments; each side stalls independently through the queue
module m68k_fast_step_executor_core
    import m68kfse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // opcode, ext_word1, ext_word2, pc, base_cycles, read_data
    input  logic                s_tuser,   // read_fault
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // next_pc, cycle_count, read_address, dest_valid,
                                           // dest_reg, dest_value, postinc_valid, postinc_reg,
                                           // ccr_flags
    output logic                m_tuser,   // handled
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;
    logic  front_busy;
    logic  q_ready;

    m68kfse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .busy       (front_busy)
    );

    m68kfse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (q_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    assign push_ready = q_ready;

    m68kfse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid || (front_busy && 1'b0)),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
